>>> design/eamat_pkg.sv
// eamat_pkg: shared constants, types and helpers for the euler angle to matrix block
// no dependencies
package eamat_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 14;
    localparam int OUT_BITS     = FRAC_BITS + 2;
    localparam int CORDIC_STEPS = 30;
    localparam int TURN_BITS    = 32;
    localparam int CW           = 34;   // cordic datapath width, q30 plus headroom
    localparam int SCW          = 32;   // sine and cosine width after cordic
    localparam int PW           = 64;   // q60 product width
    localparam int QUEUE_DEPTH  = 2;
    localparam int QA           = $clog2(QUEUE_DEPTH);
    localparam int QC           = $clog2(QUEUE_DEPTH + 1);
    localparam int BACK_STAGES  = CORDIC_STEPS + 5;
    localparam int ENTRY_SHIFT  = 60 - FRAC_BITS;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [TURN_BITS-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    typedef logic signed [OUT_BITS-1:0] entry_t;

    typedef struct packed {
        logic                 flip;
        logic signed [CW-1:0] z;
    } lane_prep_t;

    // lane 0 roll, lane 1 pitch, lane 2 yaw
    typedef lane_prep_t [2:0] angle_prep_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // fold the angle into the cordic range, remembering a half turn flip
    function automatic lane_prep_t prep_angle(input logic [ANGLE_BITS-1:0] angle);
        logic [TURN_BITS-1:0] a;
        logic [TURN_BITS-1:0] t;
        lane_prep_t           p;
        a = TURN_BITS'(angle) << (TURN_BITS - ANGLE_BITS);
        t = a + 32'h4000_0000;
        p.flip = t[TURN_BITS-1];
        if (p.flip)
        begin
            a = a + 32'h8000_0000;
        end
        p.z = CW'(signed'(a));
        return p;
    endfunction

    // round q60 half up to the output fraction, clamp to +-1.0
    function automatic entry_t finish_entry(input logic signed [PW-1:0] q);
        logic signed [PW-1:0] v;
        logic signed [PW-1:0] lim;
        v   = (q + (PW'(1) <<< (ENTRY_SHIFT - 1))) >>> ENTRY_SHIFT;
        lim = PW'(1) <<< FRAC_BITS;
        if (v > lim)
        begin
            v = lim;
        end
        if (v < -lim)
        begin
            v = -lim;
        end
        return OUT_BITS'(v);
    endfunction

endpackage

>>> design/eamat_if.sv
// eamat channel interfaces: angle input, matrix output, mode write
// depends on eamat_pkg
interface eamat_angle_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [eamat_pkg::ANGLE_BITS-1:0] roll_angle;
    logic signed [eamat_pkg::ANGLE_BITS-1:0] pitch_angle;
    logic signed [eamat_pkg::ANGLE_BITS-1:0] yaw_angle;
    modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface eamat_matrix_if;
    logic             valid;
    logic             ready;
    eamat_pkg::entry_t m11, m12, m13, m21, m22, m23, m31, m32, m33;
    modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    input ready);
    modport sink (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                  output ready);
endinterface

interface eamat_cfg_if;
    logic valid;
    logic ready;
    logic sequence_mode;
    modport source (output valid, sequence_mode, input ready);
    modport sink (input valid, sequence_mode, output ready);
endinterface

>>> design/eamat_front.sv
// eamat_front: accepts angle beats and folds each angle for the cordic
// depends on eamat_pkg, eamat_if
module eamat_front (
    eamat_angle_if.sink             in_ch,
    input  eamat_pkg::queue_status_t q_status,
    output logic                    push,
    output eamat_pkg::angle_prep_t  prep
);

    assign in_ch.ready = !q_status.full;
    assign push        = in_ch.valid && !q_status.full;

    always_comb
    begin
        prep[0] = eamat_pkg::prep_angle(in_ch.roll_angle);
        prep[1] = eamat_pkg::prep_angle(in_ch.pitch_angle);
        prep[2] = eamat_pkg::prep_angle(in_ch.yaw_angle);
    end

endmodule

>>> design/eamat_queue.sv
// eamat_queue: short queue of folded angle triples between front and back
// depends on eamat_pkg
module eamat_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  eamat_pkg::angle_prep_t   push_data,
    input  logic                     pop,
    output eamat_pkg::angle_prep_t   pop_data,
    output eamat_pkg::queue_status_t status
);

    eamat_pkg::angle_prep_t           slot_reg [eamat_pkg::QUEUE_DEPTH];
    logic [eamat_pkg::QA-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [eamat_pkg::QA-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [eamat_pkg::QC-1:0]         count_reg, count_next;

    assign status.full  = (count_reg == eamat_pkg::QC'(eamat_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/eamat_back.sv
// eamat_back: cordic pipeline, matrix products, rounding and output register
// depends on eamat_pkg
module eamat_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  eamat_pkg::angle_prep_t   prep,
    input  eamat_pkg::queue_status_t q_status,
    output logic                     pop,
    input  logic                     mode,
    input  logic                     out_ready,
    output logic                     out_valid,
    output eamat_pkg::entry_t        mat [9]
);

    localparam int CW  = eamat_pkg::CW;
    localparam int SCW = eamat_pkg::SCW;
    localparam int PW  = eamat_pkg::PW;
    localparam int NS  = eamat_pkg::CORDIC_STEPS;
    localparam int NB  = eamat_pkg::BACK_STAGES;

    logic adv;

    // cordic stages, three lanes each
    logic signed [CW-1:0] x_reg [NS][3], x_next [NS][3];
    logic signed [CW-1:0] y_reg [NS][3], y_next [NS][3];
    logic signed [CW-1:0] z_reg [NS][3], z_next [NS][3];
    logic                 f_reg [NS][3], f_next [NS][3];

    logic signed [SCW-1:0] s_reg [3], s_next [3];
    logic signed [SCW-1:0] c_reg [3], c_next [3];

    // product stage: ts, tc raw, and the eight plain products plus m31
    logic signed [PW-1:0]  p_reg [11], p_next [11];
    logic signed [SCW-1:0] ps_reg, pc_reg;
    logic signed [SCW-1:0] r_ts_reg, r_tc_reg, r_ts_next, r_tc_next;
    logic signed [PW-1:0]  r_reg [9];
    logic signed [SCW-1:0] rs_reg, rc_reg;
    logic signed [PW-1:0]  t_reg [4], t_next [4];
    logic signed [PW-1:0]  t_pass_reg [9];
    logic signed [PW-1:0]  e_reg [9], e_next [9];
    eamat_pkg::entry_t     mat_reg [9], mat_next [9];

    logic [NB-1:0] vld_reg;
    logic          out_valid_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign pop       = adv && !q_status.empty;
    assign out_valid = out_valid_reg;
    assign mat       = mat_reg;

    always_comb
    begin
        logic signed [CW-1:0] xin, yin, zin, dx, dy;
        logic                 fin;
        for (int g = 0; g < NS; g++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (g == 0)
                begin
                    xin = eamat_pkg::CORDIC_GAIN;
                    yin = '0;
                    zin = prep[l].z;
                    fin = prep[l].flip;
                end
                else
                begin
                    xin = x_reg[g-1][l];
                    yin = y_reg[g-1][l];
                    zin = z_reg[g-1][l];
                    fin = f_reg[g-1][l];
                end
                dx = yin >>> g;
                dy = xin >>> g;
                if (!zin[CW-1])
                begin
                    x_next[g][l] = xin - dx;
                    y_next[g][l] = yin + dy;
                    z_next[g][l] = zin - CW'(eamat_pkg::ATAN_TURN[g]);
                end
                else
                begin
                    x_next[g][l] = xin + dx;
                    y_next[g][l] = yin - dy;
                    z_next[g][l] = zin + CW'(eamat_pkg::ATAN_TURN[g]);
                end
                f_next[g][l] = fin;
            end
        end
    end

    // undo the half turn fold
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            s_next[l] = SCW'(f_reg[NS-1][l] ? -y_reg[NS-1][l] : y_reg[NS-1][l]);
            c_next[l] = SCW'(f_reg[NS-1][l] ? -x_reg[NS-1][l] : x_reg[NS-1][l]);
        end
    end

    // lane 0 phi, lane 1 theta, lane 2 psi
    always_comb
    begin
        p_next[0]  = s_reg[1] * s_reg[0];                 // sth*sphi
        p_next[1]  = s_reg[1] * c_reg[0];                 // sth*cphi
        p_next[2]  = c_reg[2] * c_reg[1];                 // m11
        p_next[3]  = s_reg[2] * c_reg[0];                 // spsi*cphi
        p_next[4]  = s_reg[2] * s_reg[0];                 // spsi*sphi
        p_next[5]  = s_reg[2] * c_reg[1];                 // m21
        p_next[6]  = c_reg[2] * c_reg[0];                 // cpsi*cphi
        p_next[7]  = c_reg[2] * s_reg[0];                 // cpsi*sphi
        p_next[8]  = -{{2{s_reg[1][SCW-1]}}, s_reg[1], 30'b0}; // m31
        p_next[9]  = c_reg[1] * s_reg[0];                 // m32
        p_next[10] = c_reg[1] * c_reg[0];                 // m33
    end

    always_comb
    begin
        r_ts_next = SCW'((p_reg[0] + (PW'(1) <<< 29)) >>> 30);
        r_tc_next = SCW'((p_reg[1] + (PW'(1) <<< 29)) >>> 30);
    end

    always_comb
    begin
        t_next[0] = rc_reg * r_ts_reg;   // cpsi*ts
        t_next[1] = rc_reg * r_tc_reg;   // cpsi*tc
        t_next[2] = rs_reg * r_ts_reg;   // spsi*ts
        t_next[3] = rs_reg * r_tc_reg;   // spsi*tc
    end

    // t_pass: 0 m11, 1 spsi*cphi, 2 spsi*sphi, 3 m21, 4 cpsi*cphi,
    // 5 cpsi*sphi, 6 m31, 7 m32, 8 m33
    always_comb
    begin
        e_next[0] = t_pass_reg[0];
        e_next[1] = t_reg[0] - t_pass_reg[1];
        e_next[2] = t_reg[1] + t_pass_reg[2];
        e_next[3] = t_pass_reg[3];
        e_next[4] = t_reg[2] + t_pass_reg[4];
        e_next[5] = t_reg[3] - t_pass_reg[5];
        e_next[6] = t_pass_reg[6];
        e_next[7] = t_pass_reg[7];
        e_next[8] = t_pass_reg[8];
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mat_next[r*3+k] = mode ? eamat_pkg::finish_entry(e_reg[k*3+r])
                                       : eamat_pkg::finish_entry(e_reg[r*3+k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            f_reg    <= f_next;
            s_reg    <= s_next;
            c_reg    <= c_next;
            p_reg    <= p_next;
            ps_reg   <= s_reg[2];
            pc_reg   <= c_reg[2];
            r_ts_reg <= r_ts_next;
            r_tc_reg <= r_tc_next;
            rs_reg   <= ps_reg;
            rc_reg   <= pc_reg;
            for (int i = 0; i < 9; i++)
            begin
                r_reg[i] <= p_reg[i+2];
            end
            t_reg      <= t_next;
            t_pass_reg <= r_reg;
            e_reg      <= e_next;
            mat_reg    <= mat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[NB-2:0], !q_status.empty};
            out_valid_reg <= vld_reg[NB-1];
        end
    end

endmodule

>>> design/euler_angles_to_rotation_matrix.sv
// euler_angles_to_rotation_matrix: top level, zyx direction cosine matrix from angles
// depends on eamat_pkg, eamat_if, eamat_front, eamat_queue, eamat_back
//
// usage
// - in_ch beat: roll, pitch and yaw as signed binary angles, full range is one turn
// - out_ch beat: nine matrix entries m11..m33, signed, 2^14 equals 1.0, clamped to +-1.0
// - cfg beat: sequence_mode, 0 zyx world-to-body, 1 the transpose (xyz body-to-world);
//   cfg.ready is always high, write only while no beat is in flight
// - throughput: one beat per cycle in and out while out_ch.ready stays high
// - stages: the queue slot is written at the accept edge, then 30 cordic stages and
//   six product, rounding and output stages follow
// - a two entry queue splits the front from the back; when out_ch stalls the whole
//   back pipeline holds, the queue fills and in_ch.ready drops once two beats wait in it
// - reset clears the queue, the pipeline valid bits and the mode (zyx)
module euler_angles_to_rotation_matrix (
    input  logic            clk,
    input  logic            rst_n,
    eamat_angle_if.sink     in_ch,
    eamat_matrix_if.source  out_ch,
    eamat_cfg_if.sink       cfg
);

    logic                     mode_reg;
    logic                     push;
    logic                     pop;
    eamat_pkg::angle_prep_t   push_data;
    eamat_pkg::angle_prep_t   pop_data;
    eamat_pkg::queue_status_t q_status;
    eamat_pkg::entry_t        mat [9];

    // mode register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            mode_reg <= cfg.sequence_mode;
        end
    end

    // front: fold angles, push into queue
    eamat_front u_front (
        .in_ch    (in_ch),
        .q_status (q_status),
        .push     (push),
        .prep     (push_data)
    );

    eamat_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // back: cordic and matrix pipeline, stalls as one on out_ch.ready
    eamat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .prep      (pop_data),
        .q_status  (q_status),
        .pop       (pop),
        .mode      (mode_reg),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .mat       (mat)
    );

    assign out_ch.m11 = mat[0];
    assign out_ch.m12 = mat[1];
    assign out_ch.m13 = mat[2];
    assign out_ch.m21 = mat[3];
    assign out_ch.m22 = mat[4];
    assign out_ch.m23 = mat[5];
    assign out_ch.m31 = mat[6];
    assign out_ch.m32 = mat[7];
    assign out_ch.m33 = mat[8];

`ifndef SYNTH
    // an accepted beat is in the queue at the next edge
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !q_status.empty)
        else $error("accepted beat missing from queue");

    // a full queue must hold off the input
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !in_ch.ready)
        else $error("input ready while queue full");

    // the back never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");
`endif

endmodule
